FILE: hw/rtl/ldmw_pkg.sv
// Package with shared types and constants for the longest disjoint mask window block.
`default_nettype none
package ldmw_pkg;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 6;

  typedef enum logic {
    StIdle,
    StProc
  } ldmw_state_e;

  typedef struct packed {
    logic load;    // capture a new input item
    logic drop;    // retire the oldest mask from the window
    logic insert;  // add held mask (clear window if final), write result register
  } ldmw_cmd_t;

  typedef struct packed {
    logic need_drop;  // the held mask overlaps the window, or the window is full
  } ldmw_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/longest_disjoint_mask_window_top.sv
// Top level of the longest disjoint mask window block.
//
// Input channel (in_valid_i / in_ready_o) carries one mask and its final flag
// per transfer; output channel (out_valid_o / out_ready_i) carries one result
// per input item: current window length, best length in the set, and a
// set-done flag that copies the final flag.
// Each item is captured, then the old masks that it pushes out of the window
// are removed one by one (the ring RAM yields one stored mask per cycle), and
// then the item is inserted and the result register loaded. Each mask is
// removed at most once, so on average an item pushes out at most one old mask.
// The result appears in the cycle after the insert.
// The next item is taken while a result still waits in the output register;
// the insert step waits for the drops and holds while the previous result has not been taken yet.
// Reset clears the window, its occupancy mask and the best length; the ring
// contents are not cleared and need no clearing pass. An item flagged final
// clears the same state once its result is produced.
`default_nettype none
module longest_disjoint_mask_window_top #(
  parameter int unsigned MASK_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ldmw_pkg::InWidth-1:0]  mask_value_i,
  input  wire logic                          is_final_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [ldmw_pkg::OutWidth-1:0] window_length_o,
  output logic      [ldmw_pkg::OutWidth-1:0] best_length_o,
  output logic                               set_done_o
);

  ldmw_pkg::ldmw_cmd_t    cmd;
  ldmw_pkg::ldmw_status_t status;

  ldmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ldmw_dp #(
    .MaskBits (MASK_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .mask_value_i    (mask_value_i),
    .is_final_i      (is_final_i),
    .window_length_o (window_length_o),
    .best_length_o   (best_length_o),
    .set_done_o      (set_done_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/ldmw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module ldmw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ldmw_ctrl.sv
// Controller state machine for the longest disjoint mask window block.
`default_nettype none
module ldmw_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire ldmw_pkg::ldmw_status_t status_i,
  output ldmw_pkg::ldmw_cmd_t        cmd_o
);

  ldmw_pkg::ldmw_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ldmw_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = ldmw_pkg::StProc;
        end
      end
      ldmw_pkg::StProc: begin
        if (!status_i.need_drop && out_free) begin
          state_d = ldmw_pkg::StIdle;
        end
      end
      default: state_d = ldmw_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ldmw_pkg::StIdle);
    cmd_o.load    = (state_q == ldmw_pkg::StIdle) && in_valid_i;
    cmd_o.drop    = (state_q == ldmw_pkg::StProc) && status_i.need_drop;
    cmd_o.insert  = (state_q == ldmw_pkg::StProc) && !status_i.need_drop && out_free;
    // A new result replaces a taken one in the same cycle.
    out_valid_d   = cmd_o.insert ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldmw_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ldmw_dp.sv
// Datapath: window ring, occupancy mask, counters and result register.
`default_nettype none
module ldmw_dp #(
  parameter int unsigned MaskBits = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ldmw_pkg::ldmw_cmd_t                cmd_i,
  output ldmw_pkg::ldmw_status_t                  status_o,
  input  wire logic [ldmw_pkg::InWidth-1:0]       mask_value_i,
  input  wire logic                               is_final_i,
  output logic      [ldmw_pkg::OutWidth-1:0]      window_length_o,
  output logic      [ldmw_pkg::OutWidth-1:0]      best_length_o,
  output logic                                    set_done_o
);

  localparam int unsigned CutW = (MaskBits < ldmw_pkg::InWidth) ? MaskBits : ldmw_pkg::InWidth;
  localparam int unsigned SlotW = $clog2(MaskBits);
  localparam int unsigned CntW  = $clog2(MaskBits + 1);
  localparam int unsigned SumW  = CntW + 1;

  logic [MaskBits-1:0] mask_q, mask_d;
  logic                fin_q, fin_d;
  logic [MaskBits-1:0] occ_q, occ_d;
  logic [SlotW-1:0]    oldest_q, oldest_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     best_q, best_d;
  logic [ldmw_pkg::OutWidth-1:0] wlen_q, wlen_d, blen_q, blen_d;
  logic                done_q, done_d;

  logic [MaskBits-1:0] old_mask;
  logic [SumW-1:0]     slot_sum;
  logic [SlotW-1:0]    tail_slot;
  logic [CntW-1:0]     count_inc;
  logic [CntW-1:0]     best_new;

  ldmw_ram #(
    .Width (MaskBits),
    .Depth (MaskBits)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (tail_slot),
    .wdata_i (mask_q),
    .raddr_i (oldest_d),
    .rdata_o (old_mask)
  );

  // Read data shows the entry at the current oldest slot whenever a drop uses
  // it; an entry written by an insert is read back before the next drop.
  assign status_o.need_drop = ((count_q != '0) && ((occ_q & mask_q) != '0)) ||
                              (count_q == CntW'(MaskBits));

  assign slot_sum  = SumW'(oldest_q) + SumW'(count_q);
  assign tail_slot = (slot_sum >= SumW'(MaskBits)) ? SlotW'(slot_sum - SumW'(MaskBits))
                                                   : SlotW'(slot_sum);
  assign count_inc = count_q + 1'b1;
  assign best_new  = (count_inc > best_q) ? count_inc : best_q;

  always_comb begin
    mask_d   = mask_q;
    fin_d    = fin_q;
    occ_d    = occ_q;
    oldest_d = oldest_q;
    count_d  = count_q;
    best_d   = best_q;
    wlen_d   = wlen_q;
    blen_d   = blen_q;
    done_d   = done_q;
    if (cmd_i.load) begin
      mask_d = MaskBits'(mask_value_i[CutW-1:0]);
      fin_d  = is_final_i;
    end
    if (cmd_i.drop) begin
      occ_d    = occ_q ^ old_mask;
      oldest_d = (oldest_q == SlotW'(MaskBits - 1)) ? '0 : oldest_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
    if (cmd_i.insert) begin
      wlen_d = ldmw_pkg::OutWidth'(count_inc);
      blen_d = ldmw_pkg::OutWidth'(best_new);
      done_d = fin_q;
      if (fin_q) begin
        // The final item closes the set.
        occ_d    = '0;
        oldest_d = '0;
        count_d  = '0;
        best_d   = '0;
      end else begin
        occ_d   = occ_q | mask_q;
        count_d = count_inc;
        best_d  = best_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      oldest_q <= '0;
      count_q  <= '0;
      best_q   <= '0;
    end else begin
      occ_q    <= occ_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
      best_q   <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    fin_q  <= fin_d;
    wlen_q <= wlen_d;
    blen_q <= blen_d;
    done_q <= done_d;
  end

  assign window_length_o = wlen_q;
  assign best_length_o   = blen_q;
  assign set_done_o      = done_q;

endmodule
`default_nettype wire
